FILE: hw/rtl/wwkc_pkg.sv
// Shared types, keyword table and byte-class helpers for the keyword counter.
`timescale 1ns / 1ps

package wwkc_pkg;

   localparam int WINDOW        = 12;
   localparam int NWORDS        = 6;
   localparam int KW_MAX        = 11;
   localparam int SEEN_BITS     = $clog2(WINDOW + 1);
   localparam int OUT_BITS      = 16;
   localparam int COUNT_BITS_DEF = 16;

   // Keyword text, first character in the most significant used byte.
   localparam logic [KW_MAX*8-1:0] KW_TEXT [NWORDS] = '{
      "data", "algorithm", "math", "generate", "link", "information"
   };
   localparam int KW_LEN [NWORDS] = '{4, 9, 4, 8, 4, 11};

   typedef logic [WINDOW-1:0][7:0] window_type;

   typedef struct packed {
      logic shift;   // push a folded byte into the window
      logic judge;   // check keywords ending at the judged window
      logic clear;   // page done, back to empty state
   } step_ctrl_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'd65 && c <= 8'd90) r = c + 8'd32;
      return r;
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      logic r;
      r = (c == 8'd32) || (c == 8'd9) || (c == 8'd10)
        || (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64)
        || (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
      return r;
   endfunction

endpackage

FILE: hw/rtl/wwkc_cell.sv
// One byte cell of the shifting text window.
`timescale 1ns / 1ps

module wwkc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  wwkc_pkg::step_ctrl_type ctrl,
   input  logic [7:0]            din,
   output logic [7:0]            dout
);
   import wwkc_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.clear) byte_in = '0;
      else if (ctrl.shift) byte_in = din;
   end

   always_ff @(posedge clock) begin
      if (reset) byte_ff <= '0;
      else byte_ff <= byte_in;
   end

   assign dout = byte_ff;

endmodule

FILE: hw/rtl/wwkc_word.sv
// Matcher and saturating hit counter for one keyword.
`timescale 1ns / 1ps

module wwkc_word #(
   parameter int WORD_IDX   = 0,
   parameter int COUNT_BITS = wwkc_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  wwkc_pkg::step_ctrl_type           ctrl,
   input  wwkc_pkg::window_type              win,
   input  logic [wwkc_pkg::SEEN_BITS-1:0]    seen,
   output logic [wwkc_pkg::OUT_BITS-1:0]     count_out
);
   import wwkc_pkg::*;

   localparam int LEN = KW_LEN[WORD_IDX];
   localparam logic [KW_MAX*8-1:0] TEXT = KW_TEXT[WORD_IDX];
   localparam logic [SEEN_BITS-1:0] LEN_S = SEEN_BITS'(LEN);

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] count_nx;
   logic                  text_ok;
   logic                  hit;

   always_comb begin
      text_ok = 1'b1;
      for (int k = 0; k < LEN; k++) begin
         if (win[WINDOW-LEN+k] != TEXT[(LEN-1-k)*8 +: 8]) text_ok = 1'b0;
      end
   end

   // page start before the word, or a separator just ahead of it
   assign hit = ctrl.judge && text_ok && (seen >= LEN_S)
             && ((seen == LEN_S) || is_sep(win[WINDOW-1-LEN]));

   assign count_nx = (hit && (count_ff != '1)) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      count_in = count_nx;
      if (ctrl.clear) count_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   generate
      if (COUNT_BITS > OUT_BITS) begin : g_clamp
         assign count_out = (|count_nx[COUNT_BITS-1:OUT_BITS]) ? '1
                          : count_nx[OUT_BITS-1:0];
      end else if (COUNT_BITS == OUT_BITS) begin : g_same
         assign count_out = count_nx;
      end else begin : g_ext
         assign count_out = {{(OUT_BITS-COUNT_BITS){1'b0}}, count_nx};
      end
   endgenerate

endmodule

FILE: hw/rtl/whole_word_keyword_counter.sv
// Whole-word keyword counter: window cell chain, keyword counters, result register.
// Throughput: one text byte per cycle; a page-end byte stalls only while the
//   previous result word still waits on rsp_ready.
// Latency: the result word is valid the cycle after the page-end byte is taken.
// Reset: synchronous, active high; clears window, counters and result valid.
`timescale 1ns / 1ps

module whole_word_keyword_counter #(
   parameter int COUNT_BITS = wwkc_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_text_byte,
   input  logic                          req_page_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wwkc_pkg::OUT_BITS-1:0] rsp_count_data,
   output logic [wwkc_pkg::OUT_BITS-1:0] rsp_count_algorithm,
   output logic [wwkc_pkg::OUT_BITS-1:0] rsp_count_math,
   output logic [wwkc_pkg::OUT_BITS-1:0] rsp_count_generate,
   output logic [wwkc_pkg::OUT_BITS-1:0] rsp_count_link,
   output logic [wwkc_pkg::OUT_BITS-1:0] rsp_count_information
);
   import wwkc_pkg::*;

   localparam logic [SEEN_BITS-1:0] WIN_S = SEEN_BITS'(WINDOW);

   // input side
   logic          accept;
   logic [7:0]    folded;
   logic          byte_zero;
   logic          byte_sep;
   logic          live;
   step_ctrl_type ctrl;

   // window chain: index WINDOW-1 holds the newest byte
   window_type    win_old;
   window_type    win_new;
   window_type    win_judge;

   logic [SEEN_BITS-1:0] seen_ff,    seen_in;
   logic [SEEN_BITS-1:0] seen_new;
   logic [SEEN_BITS-1:0] seen_judge;
   logic                 stopped_ff, stopped_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] counts_now [NWORDS];
   logic [OUT_BITS-1:0] counts_ff  [NWORDS];
   logic [OUT_BITS-1:0] counts_in  [NWORDS];

   // Non-final bytes always flow; a final byte needs the result slot free.
   assign req_ready = !rsp_valid_ff || rsp_ready || !req_page_end;
   assign accept    = req_valid && req_ready;

   assign folded    = fold_byte(req_text_byte);
   assign byte_zero = (req_text_byte == 8'd0);
   assign byte_sep  = is_sep(folded);
   assign live      = !stopped_ff;

   // Words are judged before a separator enters the window, when a zero byte
   // arrives (never entering), or at page end with the last byte already in. A
   // separator on the last byte cannot end a keyword, so one judge per byte is enough.
   assign ctrl.shift = accept && live && !byte_zero;
   assign ctrl.judge = accept && live && (byte_zero || byte_sep || req_page_end);
   assign ctrl.clear = accept && req_page_end;

   assign seen_new = (seen_ff < WIN_S) ? seen_ff + 1'b1 : seen_ff;

   always_comb begin
      for (int i = 0; i < WINDOW - 1; i++) win_new[i] = win_old[i+1];
      win_new[WINDOW-1] = folded;
   end

   assign win_judge  = (byte_zero || byte_sep) ? win_old : win_new;
   assign seen_judge = (byte_zero || byte_sep) ? seen_ff : seen_new;

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW; gi++) begin : g_cell
         wwkc_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .din   (win_new[gi]),
            .dout  (win_old[gi])
         );
      end
      for (gi = 0; gi < NWORDS; gi++) begin : g_word
         wwkc_word #(
            .WORD_IDX   (gi),
            .COUNT_BITS (COUNT_BITS)
         ) u_word (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .win       (win_judge),
            .seen      (seen_judge),
            .count_out (counts_now[gi])
         );
      end
   endgenerate

   always_comb begin
      seen_in    = seen_ff;
      stopped_in = stopped_ff;
      if (ctrl.clear) begin
         seen_in    = '0;
         stopped_in = 1'b0;
      end else begin
         if (ctrl.shift) seen_in = seen_new;
         if (accept && live && byte_zero) stopped_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      counts_in    = counts_ff;
      if (ctrl.clear) begin
         rsp_valid_in = 1'b1;
         counts_in    = counts_now;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      counts_ff <= counts_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_count_data        = counts_ff[0];
   assign rsp_count_algorithm   = counts_ff[1];
   assign rsp_count_math        = counts_ff[2];
   assign rsp_count_generate    = counts_ff[3];
   assign rsp_count_link        = counts_ff[4];
   assign rsp_count_information = counts_ff[5];

endmodule

FILE: hw/rtl/wwkc_checker.sv
// Port-level checks for the keyword counter, bound to the top level.
`timescale 1ns / 1ps

module wwkc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_text_byte,
   input logic        req_page_end,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_count_data,
   input logic [15:0] rsp_count_algorithm,
   input logic [15:0] rsp_count_math,
   input logic [15:0] rsp_count_generate,
   input logic [15:0] rsp_count_link,
   input logic [15:0] rsp_count_information
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count_data)
         && $stable(rsp_count_algorithm) && $stable(rsp_count_math)
         && $stable(rsp_count_generate) && $stable(rsp_count_link)
         && $stable(rsp_count_information))
      else $error("result word changed while stalled");

   // a stalled input word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_text_byte)
         && $stable(req_page_end))
      else $error("input word changed while stalled");

   // every accepted page end produces a result word next cycle
   a_page_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_page_end |=> rsp_valid)
      else $error("page end gave no result word");

   // mid-page bytes never stall, nor does a page end with no result pending
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !req_page_end || !rsp_valid |-> req_ready)
      else $error("input stalled without a pending result");

   // no result appears out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind whole_word_keyword_counter wwkc_checker u_wwkc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .req_text_byte         (req_text_byte),
   .req_page_end          (req_page_end),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_count_data        (rsp_count_data),
   .rsp_count_algorithm   (rsp_count_algorithm),
   .rsp_count_math        (rsp_count_math),
   .rsp_count_generate    (rsp_count_generate),
   .rsp_count_link        (rsp_count_link),
   .rsp_count_information (rsp_count_information)
);
